// ===== rtl/tscs_pkg.sv =====
`default_nettype none

package tscs_pkg;

    localparam int TIME_W   = 48;
    localparam int CNT_W    = 32;
    localparam int CAP_W    = 17;
    localparam int IDX_W    = 16;
    localparam int PROD_W   = TIME_W + CAP_W;
    localparam int NUM_ST   = 5;
    localparam int ST_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CAP_W-1:0] MAX_SAMPLES = CAP_W'(65536);
    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(1024);

    typedef enum logic [1:0] {
        OP_READY = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EDGE_CONT   = 2'd0,
        EDGE_CREATE = 2'd1,
        EDGE_END    = 2'd2
    } edge_kind_t;

    typedef enum logic [1:0] {
        LAST_CREATE = 2'd0,
        LAST_WAIT   = 2'd1,
        LAST_END    = 2'd2
    } last_kind_t;

    typedef enum logic [ST_W-1:0] {
        ST_RUNNING     = 3'd0,
        ST_ENDED       = 3'd1,
        ST_CREATED     = 3'd2,
        ST_CREATE_CONT = 3'd3,
        ST_WAIT_CONT   = 3'd4
    } st_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_END_TIME = 1'd0,
        CFG_CAPACITY = 1'd1
    } cfg_idx_t;

    typedef logic signed [CNT_W-1:0] cnt_t;

    // task class for ready/start events; anything unexpected counts as created
    function automatic st_t classify(input logic has_pred, input logic [1:0] pred_edge,
                                     input logic [1:0] last_kind);
        st_t k;
        k = ST_CREATED;
        if (has_pred) begin
            case (pred_edge)
                EDGE_CONT: begin
                    case (last_kind)
                        LAST_CREATE: k = ST_CREATE_CONT;
                        LAST_WAIT:   k = ST_WAIT_CONT;
                        default:     k = ST_CREATED;
                    endcase
                end
                EDGE_END: k = ST_ENDED;
                default:  k = ST_CREATED;
            endcase
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/task_state_count_sampler.sv =====
`default_nettype none

// Task state counter with time-based sampling.
// Input channel (s_*): one scheduling event per item (ready, start or end) with
// its predecessor info and a nondecreasing timestamp. Each item yields exactly
// one result item on m_*: the five task-state counters after the update, plus
// whether a sample slot was taken (recorded, with slot index and time) or a due
// sample was dropped because all slots are used (overflow).
// Configuration (cfg_*): index 0 end_time, index 1 capacity; always ready. The user
// is to write it only while no item is in flight; the block does not enforce it.
// Path: the accepting edge loads the input register, a later edge the result
// register, which raises m_valid. Throughput: one item per cycle while the receiver
// does not stall; the counter update and the 48x17 multiply-compare of the sample
// check both sit in the single stage between the two registers.
// Reset (aresetn low, synchronous): counters, sample count and last sample
// time clear, end_time clears, capacity returns to 1024, both stages empty.
// Receiver stall: the result register holds; one more item is taken into the
// input register, then s_ready drops until m_ready returns.
module task_state_count_sampler (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [1:0]                    s_op,
    input  wire                           s_has_pred,
    input  wire  [1:0]                    s_edge_kind,
    input  wire  [1:0]                    s_pred_last_kind,
    input  wire  [tscs_pkg::TIME_W-1:0]   s_event_time,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic                          m_recorded,
    output logic                          m_overflow,
    output logic [tscs_pkg::IDX_W-1:0]    m_sample_index,
    output logic [tscs_pkg::TIME_W-1:0]   m_sample_time,
    output logic signed [tscs_pkg::CNT_W-1:0] m_running_count,
    output logic signed [tscs_pkg::CNT_W-1:0] m_ended_count,
    output logic signed [tscs_pkg::CNT_W-1:0] m_created_count,
    output logic signed [tscs_pkg::CNT_W-1:0] m_create_cont_count,
    output logic signed [tscs_pkg::CNT_W-1:0] m_wait_cont_count,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [tscs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [tscs_pkg::TIME_W-1:0]   cfg_data
);
    import tscs_pkg::*;

    // configuration
    logic [TIME_W-1:0] end_time_reg;
    logic [CAP_W-1:0]  capacity_reg;

    // input stage
    logic              in_valid_reg;
    logic [1:0]        in_op_reg;
    logic              in_has_pred_reg;
    logic [1:0]        in_edge_kind_reg;
    logic [1:0]        in_last_kind_reg;
    logic [TIME_W-1:0] in_time_reg;

    // sampler state
    cnt_t              cnt_reg  [NUM_ST];
    cnt_t              cnt_next [NUM_ST];
    logic [CAP_W-1:0]  sample_count_reg;
    logic [CAP_W-1:0]  sample_count_next;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] last_time_next;

    // result stage
    logic              out_valid_reg;
    logic              out_recorded_reg;
    logic              out_overflow_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [TIME_W-1:0] out_time_reg;
    cnt_t              out_cnt_reg [NUM_ST];

    logic              advance;
    st_t               k;
    logic [CAP_W-1:0]  cap_eff;
    logic [CAP_W-1:0]  left;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] need;
    logic [PROD_W-1:0] prod;
    logic              due;
    logic              take;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        k = classify(in_has_pred_reg, in_edge_kind_reg, in_last_kind_reg);
        for (int i = 0; i < NUM_ST; i++) begin
            cnt_next[i] = cnt_reg[i];
        end
        case (in_op_reg)
            OP_READY: begin
                cnt_next[k] = cnt_reg[k] + cnt_t'(1);
            end
            OP_START: begin
                cnt_next[k]          = cnt_reg[k] - cnt_t'(1);
                cnt_next[ST_RUNNING] = cnt_reg[ST_RUNNING] + cnt_t'(1);
            end
            OP_END: begin
                cnt_next[ST_RUNNING] = cnt_reg[ST_RUNNING] - cnt_t'(1);
            end
            default: begin
            end
        endcase

        cap_eff = (capacity_reg > MAX_SAMPLES) ? MAX_SAMPLES : capacity_reg;
        left    = (sample_count_reg < cap_eff) ? cap_eff - sample_count_reg : '0;
        delta   = (in_time_reg > last_time_reg) ? in_time_reg - last_time_reg : '0;
        need    = end_time_reg - last_time_reg;
        // delta >= ceil(need / left)  <=>  delta * left >= need
        prod    = PROD_W'(delta) * PROD_W'(left);
        due     = (end_time_reg <= last_time_reg) ||
                  ((left != '0) && (prod >= PROD_W'(need)));
        take    = due && (left != '0);

        sample_count_next = take ? sample_count_reg + CAP_W'(1) : sample_count_reg;
        last_time_next    = take ? in_time_reg : last_time_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_time_reg <= '0;
            capacity_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_END_TIME: end_time_reg <= cfg_data;
                CFG_CAPACITY: capacity_reg <= cfg_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_op_reg        <= s_op;
            in_has_pred_reg  <= s_has_pred;
            in_edge_kind_reg <= s_edge_kind;
            in_last_kind_reg <= s_pred_last_kind;
            in_time_reg      <= s_event_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ST; i++) begin
                cnt_reg[i] <= '0;
            end
            sample_count_reg <= '0;
            last_time_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (advance) begin
                for (int i = 0; i < NUM_ST; i++) begin
                    cnt_reg[i] <= cnt_next[i];
                end
                sample_count_reg <= sample_count_next;
                last_time_reg    <= last_time_next;
                out_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            for (int i = 0; i < NUM_ST; i++) begin
                out_cnt_reg[i] <= cnt_next[i];
            end
            out_recorded_reg <= take;
            out_overflow_reg <= due && !take;
            out_index_reg    <= take ? sample_count_reg[IDX_W-1:0] : '0;
            out_time_reg     <= take ? in_time_reg : '0;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_recorded          = out_recorded_reg;
    assign m_overflow          = out_overflow_reg;
    assign m_sample_index      = out_index_reg;
    assign m_sample_time       = out_time_reg;
    assign m_running_count     = out_cnt_reg[ST_RUNNING];
    assign m_ended_count       = out_cnt_reg[ST_ENDED];
    assign m_created_count     = out_cnt_reg[ST_CREATED];
    assign m_create_cont_count = out_cnt_reg[ST_CREATE_CONT];
    assign m_wait_cont_count   = out_cnt_reg[ST_WAIT_CONT];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_count_reg <= MAX_SAMPLES)
        else $error("sample count beyond maximum");

    a_rec_xor_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_recorded && m_overflow))
        else $error("recorded and overflow both set");

    a_rec_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_recorded) |->
            (last_time_reg == m_sample_time) &&
            (sample_count_reg[IDX_W-1:0] == m_sample_index + IDX_W'(1)))
        else $error("shown sample disagrees with sampler state");

    a_no_sample_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_recorded) |-> (m_sample_time == '0) && (m_sample_index == '0))
        else $error("sample fields nonzero without a sample");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipe");

endmodule

`default_nettype wire

// ===== tb/tb_task_state_count_sampler.sv =====
`default_nettype none

module tb_task_state_count_sampler;
    import tscs_pkg::*;

    // input codes the package leaves unnamed; the block must still take them
    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [1:0] EDGE_OTHER = 2'd3;
    localparam logic [1:0] LAST_OTHER = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [TIME_W-1:0] T_FAR    = 48'h100_0000_0000;
    localparam int PHASE_EVENTS = 246;
    localparam int IDLE_LIMIT   = 4000;
    localparam int FULL_STALL   = 300;

    typedef struct packed {
        logic              recorded;
        logic              overflow;
        logic [IDX_W-1:0]  index;
        logic [TIME_W-1:0] stamp;
        cnt_t              running;
        cnt_t              ended;
        cnt_t              created;
        cnt_t              create_cont;
        cnt_t              wait_cont;
    } tally_t;

    class sample_board;
        cnt_t              state_cnt [NUM_ST];
        logic [CAP_W-1:0]  taken;
        logic [TIME_W-1:0] last_stamp;
        logic [TIME_W-1:0] end_time;
        logic [CAP_W-1:0]  capacity;
        tally_t            expected_q[$];
        int                fails;
        int                n_checked;
        int                n_recorded;
        int                n_dropped;

        function new();
            foreach (state_cnt[i]) state_cnt[i] = '0;
            taken      = '0;
            last_stamp = '0;
            end_time   = '0;
            capacity   = CAP_RESET;
            fails      = 0;
            n_checked  = 0;
            n_recorded = 0;
            n_dropped  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [TIME_W-1:0] data);
            case (idx)
                CFG_END_TIME: end_time = data;
                CFG_CAPACITY: capacity = data[CAP_W-1:0];
                default: begin
                end
            endcase
        endfunction

        function st_t task_class(logic has_pred, logic [1:0] ek, logic [1:0] lk);
            if (!has_pred) return ST_CREATED;
            if (ek == EDGE_END) return ST_ENDED;
            if (ek != EDGE_CONT) return ST_CREATED;
            if (lk == LAST_CREATE) return ST_CREATE_CONT;
            if (lk == LAST_WAIT) return ST_WAIT_CONT;
            return ST_CREATED;
        endfunction

        // slots are spread evenly over what is left of the run
        function bit due_now(logic [TIME_W-1:0] t, logic [CAP_W-1:0] left);
            logic [63:0] delta;
            logic [63:0] need;
            if (end_time <= last_stamp) return 1'b1;
            if (left == 0) return 1'b0;
            delta = (t > last_stamp) ? 64'(t - last_stamp) : 64'd0;
            need  = 64'(end_time - last_stamp);
            return delta >= (need + 64'(left) - 64'd1) / 64'(left);
        endfunction

        function void note_event(logic [1:0] op, logic has_pred, logic [1:0] ek,
                                 logic [1:0] lk, logic [TIME_W-1:0] t);
            tally_t           e;
            st_t              k;
            logic [CAP_W-1:0] cap_eff;
            logic [CAP_W-1:0] left;
            if (op == OP_READY) begin
                k = task_class(has_pred, ek, lk);
                state_cnt[k] += 1;
            end else if (op == OP_START) begin
                k = task_class(has_pred, ek, lk);
                state_cnt[k] -= 1;
                state_cnt[ST_RUNNING] += 1;
            end else if (op == OP_END) begin
                state_cnt[ST_RUNNING] -= 1;
            end
            cap_eff = (capacity < MAX_SAMPLES) ? capacity : MAX_SAMPLES;
            left    = (taken < cap_eff) ? cap_eff - taken : '0;
            e = '0;
            if (due_now(t, left)) begin
                if (left != 0) begin
                    e.recorded = 1'b1;
                    e.index    = taken[IDX_W-1:0];
                    e.stamp    = t;
                    last_stamp = t;
                    taken      = taken + 1'b1;
                end else begin
                    e.overflow = 1'b1;
                end
            end
            e.running     = state_cnt[ST_RUNNING];
            e.ended       = state_cnt[ST_ENDED];
            e.created     = state_cnt[ST_CREATED];
            e.create_cont = state_cnt[ST_CREATE_CONT];
            e.wait_cont   = state_cnt[ST_WAIT_CONT];
            expected_q.push_back(e);
        endfunction

        task report_mismatch(string msg);
            $display("%0t: %s", $time, msg);
            fails++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                          n_checked, name, got, want));
        endtask

        task check_result(tally_t got);
            tally_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result item with no event outstanding");
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (want.recorded) n_recorded++;
            if (want.overflow) n_dropped++;
            compare_field("recorded", got.recorded, want.recorded);
            compare_field("overflow", got.overflow, want.overflow);
            compare_field("sample_index", got.index, want.index);
            compare_field("sample_time", got.stamp, want.stamp);
            compare_field("running_count", got.running, want.running);
            compare_field("ended_count", got.ended, want.ended);
            compare_field("created_count", got.created, want.created);
            compare_field("create_cont_count", got.create_cont, want.create_cont);
            compare_field("wait_cont_count", got.wait_cont, want.wait_cont);
        endtask
    endclass

    logic                        aclk             = 1'b0;
    logic                        aresetn          = 1'b0;
    logic                        s_valid          = 1'b0;
    wire                         s_ready;
    logic [1:0]                  s_op             = '0;
    logic                        s_has_pred       = 1'b0;
    logic [1:0]                  s_edge_kind      = '0;
    logic [1:0]                  s_pred_last_kind = '0;
    logic [TIME_W-1:0]           s_event_time     = '0;
    wire                         m_valid;
    logic                        m_ready          = 1'b0;
    wire                         m_recorded;
    wire                         m_overflow;
    wire  [IDX_W-1:0]            m_sample_index;
    wire  [TIME_W-1:0]           m_sample_time;
    wire  signed [CNT_W-1:0]     m_running_count;
    wire  signed [CNT_W-1:0]     m_ended_count;
    wire  signed [CNT_W-1:0]     m_created_count;
    wire  signed [CNT_W-1:0]     m_create_cont_count;
    wire  signed [CNT_W-1:0]     m_wait_cont_count;
    logic                        cfg_valid        = 1'b0;
    wire                         cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index        = '0;
    logic [TIME_W-1:0]           cfg_data         = '0;

    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    int          ready_hold        = 0;
    int          quiet_cycles      = 0;
    int          events_sent       = 0;
    int          settings_used     = 0;
    int          waiting_tasks     = 0;
    int          running_tasks     = 0;
    int unsigned jump_max          = 0;
    logic [TIME_W-1:0] tnow        = '0;

    sample_board book = new();

    task_state_count_sampler i_dut (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin : result_side
        tally_t got;
        if (m_valid && m_ready) begin
            got.recorded    = m_recorded;
            got.overflow    = m_overflow;
            got.index       = m_sample_index;
            got.stamp       = m_sample_time;
            got.running     = m_running_count;
            got.ended       = m_ended_count;
            got.created     = m_created_count;
            got.create_cont = m_create_cont_count;
            got.wait_cont   = m_wait_cont_count;
            book.check_result(got);
        end
        if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, book.pending());
            $display("tb_task_state_count_sampler: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_event(logic [1:0] op, logic hp, logic [1:0] ek, logic [1:0] lk,
                              logic [TIME_W-1:0] t);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_has_pred       <= hp;
        s_edge_kind      <= ek;
        s_pred_last_kind <= lk;
        s_event_time     <= t;
        do @(posedge aclk); while (!s_ready);
        book.note_event(op, hp, ek, lk, t);
        events_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (book.pending() != 0);
    endtask

    task automatic set_regs(logic [TIME_W-1:0] end_t, logic [TIME_W-1:0] cap_word);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_END_TIME;
        cfg_data  <= end_t;
        do @(posedge aclk); while (!cfg_ready);
        book.write_reg(CFG_END_TIME, end_t);
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= cap_word;
        do @(posedge aclk); while (!cfg_ready);
        book.write_reg(CFG_CAPACITY, cap_word);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly ready -> start -> end lifecycles, with some noise and odd codes
    task automatic random_event();
        int                r;
        logic [1:0]        op;
        logic [1:0]        ek;
        logic [1:0]        lk;
        logic              hp;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] step;
        r  = $urandom_range(99);
        hp = ($urandom_range(7) != 0);
        ek = 2'($urandom_range(2));
        lk = 2'($urandom_range(1));
        if (r < 4) begin
            op = OP_NONE;
        end else if (r < 10) begin
            op = 2'($urandom_range(3));
            hp = 1'($urandom_range(1));
            ek = 2'($urandom_range(3));
            lk = 2'($urandom_range(3));
        end else if (waiting_tasks == 0 || r < 40) begin
            op = OP_READY;
            waiting_tasks++;
        end else if (running_tasks == 0 || r < 70) begin
            op = OP_START;
            waiting_tasks--;
            running_tasks++;
        end else begin
            op = OP_END;
            running_tasks--;
        end

        r    = $urandom_range(99);
        step = '0;
        if (r < 3)
            step = TIME_W'($urandom_range(jump_max));
        else if (r >= 15)
            step = TIME_W'($urandom_range(2000, 1));
        tnow = (TIME_MAX - tnow < step) ? TIME_MAX : tnow + step;
        t = tnow;
        if ($urandom_range(99) < 4)
            t = (tnow > 3000) ? tnow - TIME_W'($urandom_range(3000, 1)) : '0;
        send_event(op, hp, ek, lk, t);
    endtask

    initial begin : stimulus
        logic [TIME_W-1:0] end_t;
        logic [CAP_W-1:0]  cap;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset end_time is zero, so every event takes a slot
        send_event(OP_READY, 1'b0, EDGE_OTHER, LAST_OTHER, 48'd0);
        send_event(OP_READY, 1'b1, EDGE_CONT, LAST_CREATE, 48'd1);
        send_event(OP_READY, 1'b1, EDGE_CONT, LAST_WAIT, 48'd2);
        send_event(OP_READY, 1'b1, EDGE_CONT, LAST_END, 48'd3);
        send_event(OP_READY, 1'b1, EDGE_CONT, LAST_OTHER, 48'd4);
        send_event(OP_READY, 1'b1, EDGE_CREATE, LAST_WAIT, 48'd5);
        send_event(OP_READY, 1'b1, EDGE_END, LAST_CREATE, 48'd6);
        send_event(OP_READY, 1'b1, EDGE_OTHER, LAST_CREATE, 48'd7);
        send_event(OP_START, 1'b1, EDGE_CONT, LAST_CREATE, 48'd8);
        send_event(OP_START, 1'b1, EDGE_CONT, LAST_WAIT, 48'd9);
        send_event(OP_START, 1'b1, EDGE_END, LAST_END, 48'd10);
        send_event(OP_START, 1'b0, EDGE_CREATE, LAST_CREATE, 48'd11);
        send_event(OP_END, 1'b1, EDGE_CONT, LAST_WAIT, 48'd12);
        send_event(OP_NONE, 1'b1, EDGE_OTHER, LAST_OTHER, 48'd13);
        send_event(OP_END, 1'b0, EDGE_CONT, LAST_CREATE, TIME_MAX);
        send_event(OP_READY, 1'b1, EDGE_CONT, LAST_WAIT, 48'd3);

        // no slots at all: the due sample is dropped
        drain();
        set_regs('0, '0);
        send_event(OP_READY, 1'b1, EDGE_END, LAST_CREATE, 48'd4);

        // capacity above the slot store clamps; junk above the field is ignored
        drain();
        set_regs(TIME_MAX, {31'($urandom()), 17'h1FFFF});
        send_event(OP_START, 1'b1, EDGE_CREATE, LAST_WAIT, 48'd100);
        send_event(OP_END, 1'b1, EDGE_CONT, LAST_CREATE, T_FAR);

        // slots used up: before end_time nothing due or dropped, at end_time zero a drop, then one more slot
        drain();
        set_regs(TIME_MAX, 48'd17);
        send_event(OP_READY, 1'b0, EDGE_CONT, LAST_CREATE, T_FAR + 48'd2);
        drain();
        set_regs('0, 48'd17);
        send_event(OP_START, 1'b1, EDGE_CONT, LAST_WAIT, T_FAR + 48'd4);
        drain();
        set_regs('0, 48'd18);
        send_event(OP_READY, 1'b1, EDGE_CONT, LAST_WAIT, T_FAR + 48'd6);
        send_event(OP_END, 1'b1, EDGE_CONT, LAST_WAIT, T_FAR + 48'd8);
        tnow = T_FAR + 48'd10;

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin
                    sender_idle_pct   = 14;
                    receiver_idle_pct = 88;
                end
                1: begin
                    sender_idle_pct   = 88;
                    receiver_idle_pct = 14;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            jump_max = 0;
            drain();
            case (ph)
                0: begin
                    end_t = tnow + 48'd400_000;
                    cap   = book.taken + 17'd60;
                end
                1: begin
                    end_t = tnow + 48'd150_000;
                    cap   = book.taken + 17'd15;
                end
                2: begin
                    end_t    = tnow + 48'd300_000;
                    cap      = 17'h1FFFF;
                    jump_max = 100_000;
                end
                3: begin
                    // end_time already behind: every event is due with no slot
                    end_t = book.last_stamp;
                    cap   = '0;
                end
                4: begin
                    end_t = tnow + 48'd20_000;
                    cap   = book.taken + 17'd100;
                end
                default: begin
                    tnow     = TIME_MAX - 48'd200_000;
                    end_t    = TIME_MAX;
                    cap      = book.taken + 17'd30;
                    jump_max = 32'hFFFF_FFFF;
                end
            endcase
            set_regs(end_t, TIME_W'(cap));
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (ph == 2 && n == 100) ready_hold = FULL_STALL;
                if (ph == 0 && n == 120) drain();
                random_event();
            end
        end

        drain();
        repeat (8) @(posedge aclk);

        $display("ran %0d events under %0d register settings: %0d samples taken, %0d dropped",
                 events_sent, settings_used, book.n_recorded, book.n_dropped);
        $display("idle mixes 14/88, 88/14 and none, one long result stall, one input pause");
        if (book.fails == 0) begin
            $display("tb_task_state_count_sampler: PASS");
        end else begin
            $display("%0d mismatches", book.fails);
            $display("tb_task_state_count_sampler: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tscs_pkg.sv
rtl/task_state_count_sampler.sv
tb/tb_task_state_count_sampler.sv
